[hdl/text_to_page_framebuffer_writer_macros.svh]
// Assertion macros used by the datapath of the frame store writer.
`ifndef TEXT_TO_PAGE_FRAMEBUFFER_WRITER_MACROS_SVH
`define TEXT_TO_PAGE_FRAMEBUFFER_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tpfw_pkg.sv]
package tpfw_pkg;

    localparam int GLYPH_WIDTH = 5;

    localparam logic [7:0] CODE_FIRST = 8'h20;
    localparam logic [7:0] CODE_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_FOUR  = 8'h34;

    typedef enum logic [1:0] {
        SIZE_NORMAL,
        SIZE_DOUBLE,
        SIZE_QUAD
    } size_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic draw_char;
        logic last_step;
        logic step_ok;
        logic flush_ok;
    } dp_status_t;

    // Column 0 of each glyph sits in the most significant byte.
    localparam logic [39:0] GLYPH_FONT [0:94] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_03_00_03_00, 40'h14_3E_14_3E_14,
        40'h24_2A_7F_2A_12, 40'h43_33_08_66_61, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_04_02_7F_00, 40'h42_61_51_49_46, 40'h22_41_49_49_36,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3E_49_49_49_32, 40'h01_01_71_09_07,
        40'h36_49_49_49_36, 40'h26_49_49_49_3E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
        40'h3E_41_59_55_5E, 40'h7E_09_09_09_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_41_49_3A,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h30_40_40_40_3F, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_02_04_08_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h1E_21_21_21_5E, 40'h7F_09_09_09_76, 40'h26_49_49_49_32,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_10_20_7F,
        40'h41_22_1C_22_41, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_00_00,
        40'h02_04_08_10_20, 40'h00_00_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_44_44_44_38, 40'h38_44_44_44_44,
        40'h38_44_44_44_7F, 40'h38_54_54_54_18, 40'h04_04_7E_05_05, 40'h08_54_54_54_3C,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
        40'h00_41_7F_40_00, 40'h7C_04_78_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
        40'h7C_14_14_14_08, 40'h08_14_14_14_7C, 40'h00_7C_08_04_04, 40'h48_54_54_54_20,
        40'h04_04_3F_44_44, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
        40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_41,
        40'h00_00_7F_00_00, 40'h41_41_36_08_00, 40'h02_01_02_04_02
    };

    // Unprintable codes give a blank column.
    function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
        logic [39:0] entry;
        logic [6:0]  idx;
        entry = '0;
        idx   = 7'(code - CODE_FIRST);
        if (code >= CODE_FIRST && code <= CODE_LAST) begin
            entry = GLYPH_FONT[idx];
        end
        case (col)
            3'd0:    glyph_col = entry[39:32];
            3'd1:    glyph_col = entry[31:24];
            3'd2:    glyph_col = entry[23:16];
            3'd3:    glyph_col = entry[15:8];
            default: glyph_col = entry[7:0];
        endcase
    endfunction

    // Each font bit covers two pixel rows.
    function automatic logic [7:0] spread(input logic [3:0] nib);
        spread = {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
    endfunction

endpackage

[hdl/tpfw_ctrl.sv]
module tpfw_ctrl
    import tpfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       in_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.draw_char)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (status.step_ok && status.last_step)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign cmd.accept = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step   = (state_reg == ST_DRAW) && status.step_ok;
    assign cmd.flush  = (state_reg == ST_FLUSH) && status.flush_ok;
    assign in_stall   = stall_reg;

endmodule

[hdl/tpfw_datapath.sv]
`include "text_to_page_framebuffer_writer_macros.svh"

module tpfw_datapath
    import tpfw_pkg::*;
#(
    parameter int PAGE_WIDTH = 128,
    parameter int PAGE_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  logic       new_string,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] store_address,
    output logic [7:0] pixel_byte,
    output logic       last_write
);

    localparam int STORE_SIZE = PAGE_WIDTH * PAGE_COUNT;
    localparam int PTR_W      = $clog2(STORE_SIZE + 1);
    localparam int ADDR_W     = $clog2(STORE_SIZE + PAGE_WIDTH + 2);
    localparam int COL_W      = $clog2(PAGE_WIDTH);
    localparam int PAGE_W     = $clog2(PAGE_COUNT);

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    size_t             size_reg, size_next;
    logic [7:0]        code_reg, code_next;
    logic [2:0]        gcol_reg, gcol_next;
    logic [1:0]        sub_reg, sub_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [PTR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]        pend_byte_reg, pend_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [9:0]        out_addr_reg, out_addr_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [PTR_W-1:0]  eff_ptr;
    logic [COL_W-1:0]  eff_col;
    logic [PAGE_W-1:0] eff_page;
    size_t             eff_size;
    logic [PAGE_W:0]   page_inc;
    logic              at_start;
    logic              is_pipe;
    logic              is_digit;
    logic [1:0]        last_sub;
    logic [ADDR_W-1:0] cand_offset;
    logic [ADDR_W-1:0] cand_addr;
    logic              cand_valid;
    logic [7:0]        glyph_byte;
    logic [7:0]        cand_byte;
    logic              out_free;
    logic [PTR_W-1:0]  adv1_ptr;
    logic [COL_W-1:0]  adv1_col;

    function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p);
        adv_ptr = (p < PTR_W'(STORE_SIZE)) ? p + 1'b1 : p;
    endfunction

    function automatic logic [COL_W-1:0] adv_col(input logic [PTR_W-1:0] p,
                                                 input logic [COL_W-1:0] c);
        adv_col = c;
        if (p < PTR_W'(STORE_SIZE))
        begin
            adv_col = (c == COL_W'(PAGE_WIDTH - 1)) ? '0 : c + 1'b1;
        end
    endfunction

    assign eff_ptr  = new_string ? '0 : ptr_reg;
    assign eff_col  = new_string ? '0 : col_reg;
    assign eff_page = new_string ? '0 : page_reg;
    assign eff_size = new_string ? SIZE_NORMAL : size_reg;
    assign page_inc = (PAGE_W + 1)'(eff_page) + 1'b1;
    assign at_start = (eff_col == '0);
    assign is_pipe  = (char_code == CHAR_PIPE);
    assign is_digit = at_start &&
                      (char_code == CHAR_ONE || char_code == CHAR_TWO || char_code == CHAR_FOUR);

    assign adv1_ptr = adv_ptr(ptr_reg);
    assign adv1_col = adv_col(ptr_reg, col_reg);

    always_comb
    begin
        case (size_reg)
            SIZE_QUAD:   last_sub = 2'd3;
            SIZE_DOUBLE: last_sub = 2'd1;
            default:     last_sub = 2'd0;
        endcase
    end

    // Quad order per font column: right then left on this page, then the page below.
    always_comb
    begin
        cand_offset = '0;
        if (size_reg == SIZE_QUAD)
        begin
            case (sub_reg)
                2'd0:    cand_offset = ADDR_W'(1);
                2'd1:    cand_offset = '0;
                2'd2:    cand_offset = ADDR_W'(PAGE_WIDTH + 1);
                default: cand_offset = ADDR_W'(PAGE_WIDTH);
            endcase
        end
    end

    assign cand_addr  = ADDR_W'(ptr_reg) + cand_offset;
    assign cand_valid = (cand_addr < ADDR_W'(STORE_SIZE));
    assign glyph_byte = glyph_col(code_reg, gcol_reg);
    assign cand_byte  = (size_reg != SIZE_QUAD) ? glyph_byte :
                        (sub_reg < 2'd2)        ? spread(glyph_byte[3:0]) :
                                                  spread(glyph_byte[7:4]);
    assign out_free   = !out_valid_reg || !out_stall;

    assign status.draw_char = !is_pipe && !is_digit;
    assign status.last_step = (gcol_reg == 3'(GLYPH_WIDTH - 1)) && (sub_reg == last_sub);
    assign status.step_ok   = !cand_valid || !pend_valid_reg || out_free;
    assign status.flush_ok  = !pend_valid_reg || out_free;

    always_comb
    begin
        ptr_next        = ptr_reg;
        col_next        = col_reg;
        page_next       = page_reg;
        size_next       = size_reg;
        code_next       = code_reg;
        gcol_next       = gcol_reg;
        sub_next        = sub_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if (cmd.accept)
        begin
            ptr_next  = eff_ptr;
            col_next  = eff_col;
            page_next = eff_page;
            size_next = eff_size;
            code_next = char_code;
            gcol_next = '0;
            sub_next  = '0;
            if (is_pipe)
            begin
                col_next = '0;
                if (page_inc < (PAGE_W + 1)'(PAGE_COUNT))
                begin
                    page_next = PAGE_W'(page_inc);
                    ptr_next  = PTR_W'(page_inc * PAGE_WIDTH);
                end
                else
                begin
                    page_next = PAGE_W'(PAGE_COUNT - 1);
                    ptr_next  = PTR_W'(STORE_SIZE);
                end
            end
            else if (is_digit)
            begin
                ptr_next = adv_ptr(eff_ptr);
                col_next = adv_col(eff_ptr, eff_col);
                case (char_code)
                    CHAR_TWO:  size_next = SIZE_DOUBLE;
                    CHAR_FOUR: size_next = SIZE_QUAD;
                    default:   size_next = SIZE_NORMAL;
                endcase
            end
        end
        else if (cmd.step)
        begin
            if (size_reg != SIZE_QUAD)
            begin
                ptr_next = adv1_ptr;
                col_next = adv1_col;
            end
            else if (sub_reg == 2'd3)
            begin
                ptr_next = adv_ptr(adv1_ptr);
                col_next = adv_col(adv1_ptr, adv1_col);
            end
            if (sub_reg == last_sub)
            begin
                sub_next  = '0;
                gcol_next = gcol_reg + 1'b1;
            end
            else
            begin
                sub_next = sub_reg + 1'b1;
            end
            if (cand_valid)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = 10'(pend_addr_reg);
                    out_byte_next  = pend_byte_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_addr_next  = PTR_W'(cand_addr);
                pend_byte_next  = cand_byte;
            end
        end
        else if (cmd.flush)
        begin
            // The gap column after the glyph.
            ptr_next = adv1_ptr;
            col_next = adv1_col;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_addr_next   = 10'(pend_addr_reg);
                out_byte_next   = pend_byte_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            col_reg        <= '0;
            page_reg       <= '0;
            size_reg       <= SIZE_NORMAL;
            gcol_reg       <= '0;
            sub_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg        <= ptr_next;
            col_reg        <= col_next;
            page_reg       <= page_next;
            size_reg       <= size_next;
            gcol_reg       <= gcol_next;
            sub_reg        <= sub_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        pend_addr_reg <= pend_addr_next;
        pend_byte_reg <= pend_byte_next;
        out_addr_reg  <= out_addr_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign store_address = out_addr_reg;
    assign pixel_byte    = out_byte_reg;
    assign last_write    = out_last_reg;

    `TPFW_ASSERT_NOW(a_ptr_range, 1'b1, ptr_reg <= PTR_W'(STORE_SIZE), "pointer beyond store end")
    `TPFW_ASSERT_NOW(a_col_at_end, ptr_reg == PTR_W'(STORE_SIZE), col_reg == '0, "column not zero at store end")
    `TPFW_ASSERT_NOW(a_pend_range, pend_valid_reg, pend_addr_reg < PTR_W'(STORE_SIZE), "pending write out of store")
    `TPFW_ASSERT_NOW(a_sub_range, 1'b1, sub_reg <= last_sub, "sub-step beyond size")
    `TPFW_ASSERT_NEXT(a_flush_last, cmd.flush && pend_valid_reg, out_valid_reg && out_last_reg, "flush lost last word")

endmodule

[hdl/text_to_page_framebuffer_writer.sv]
// Renders text characters in a 5x7 font into a page-organized monochrome frame
// store held outside the block, PAGE_COUNT pages of PAGE_WIDTH bytes, one word per
// byte write. A drawing character is accepted while idle; the glyph sequencer then
// takes one write slot per cycle unless the output stalls (5 slots in normal, 10 in
// double, 20 in quad size), and a closing step sends the last pending word;
// writes that fall at or beyond the store end take their slot but are not sent.
// A page break, or a size digit at the start of a page row, is accepted while
// idle and sends nothing. The final word of each character that sends any word
// carries last_write; the input stalls until that word is registered for output.
module text_to_page_framebuffer_writer
    import tpfw_pkg::*;
#(
    parameter int PAGE_WIDTH = 128,
    parameter int PAGE_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       new_string,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] store_address,
    output logic [7:0] pixel_byte,
    output logic       last_write
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tpfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tpfw_datapath #(
        .PAGE_WIDTH (PAGE_WIDTH),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .new_string    (new_string),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .store_address (store_address),
        .pixel_byte    (pixel_byte),
        .last_write    (last_write)
    );

endmodule

[tb/text_to_page_framebuffer_writer_tb.sv]
`timescale 1ns / 100ps

module text_to_page_framebuffer_writer_tb
    import tpfw_pkg::*;
();

    localparam int PW          = 128;
    localparam int PC          = 8;
    localparam int STORE_END   = PW * PC;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 30;
    localparam int RANDOM_PER_PHASE = 96;

    typedef struct packed {
        logic [9:0] addr;
        logic [7:0] pix;
        logic       last;
    } store_write_t;

    typedef struct packed {
        logic       ns;
        logic [7:0] code;
        logic       typed;
        logic [4:0] count;
        logic [9:0] a0;
        logic [7:0] b0;
    } script_row_t;

    // Column 0 of each glyph is the most significant byte.
    localparam logic [39:0] FONT_COLUMNS [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0003000300, 40'h143E143E14, 40'h242A7F2A12,
        40'h4333086661, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h0004027F00, 40'h4261514946, 40'h2241494936,
        40'h1814127F10, 40'h2745454539, 40'h3E49494932, 40'h0101710907, 40'h3649494936,
        40'h264949493E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h3E4159555E, 40'h7E0909097E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4141493A,
        40'h7F0808087F, 40'h00417F4100, 40'h304040403F, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0204087F, 40'h3E4141413E, 40'h7F09090906, 40'h1E2121215E,
        40'h7F09090976, 40'h2649494932, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h7F2010207F, 40'h41221C2241, 40'h0708700807, 40'h6151494543, 40'h007F410000,
        40'h0204081020, 40'h0000417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F44444438, 40'h3844444444, 40'h384444447F, 40'h3854545418,
        40'h04047E0505, 40'h085454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414147C, 40'h007C080404, 40'h4854545420, 40'h04043F4444,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364141, 40'h00007F0000, 40'h4141360800, 40'h0201020402
    };

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{1'b1, 8'h41,      1'b1, 5'd5,  10'd0,   8'h7E},
        '{1'b0, 8'h00,      1'b1, 5'd5,  10'd6,   8'h00},
        '{1'b0, 8'hFF,      1'b1, 5'd5,  10'd12,  8'h00},
        '{1'b0, CODE_LAST,  1'b1, 5'd5,  10'd18,  8'h02},
        '{1'b0, CODE_FIRST, 1'b1, 5'd5,  10'd24,  8'h00},
        '{1'b0, CHAR_ONE,   1'b1, 5'd5,  10'd30,  8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_TWO,   1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, 8'h57,      1'b1, 5'd10, 10'd129, 8'h7F},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_FOUR,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, 8'h4D,      1'b1, 5'd20, 10'd258, 8'hFF},
        '{1'b0, 8'hC3,      1'b1, 5'd20, 10'd269, 8'h00},
        '{1'b1, CHAR_FOUR,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, 8'h4D,      1'b1, 5'd10, 10'd897, 8'hFF},
        '{1'b0, CHAR_PIPE,  1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, CHAR_TWO,   1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b0, 8'h41,      1'b1, 5'd0,  10'd0,   8'h00},
        '{1'b1, 8'h7A,      1'b1, 5'd5,  10'd0,   8'h44}
    };

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic       new_string = 1'b0;
    logic [7:0] char_code  = 8'h00;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [9:0] store_address;
    logic [7:0] pixel_byte;
    logic       last_write;

    store_write_t pending_writes [$];
    store_write_t oldest_write;
    int unsigned  cursor      = 0;
    int unsigned  page_row    = 0;
    size_t        glyph_size  = SIZE_NORMAL;
    int           last_count  = 0;
    int           errors      = 0;
    int           idle_pct    = 0;
    int           stall_pct   = 0;
    int           cycle_count = 0;
    int           hold_cycles = 0;
    logic         hold_toggle = 1'b0;
    logic         hold_seen   = 1'b0;

    text_to_page_framebuffer_writer #(
        .PAGE_WIDTH(PW),
        .PAGE_COUNT(PC)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .new_string(new_string),
        .char_code(char_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .store_address(store_address),
        .pixel_byte(pixel_byte),
        .last_write(last_write)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] double_rows(input logic [3:0] nib);
        logic [7:0] r;
        r = '0;
        for (int b = 0; b < 4; b++)
        begin
            r[2*b +: 2] = {2{nib[b]}};
        end
        return r;
    endfunction

    function automatic void bump_cursor();
        if (cursor < STORE_END)
        begin
            cursor++;
        end
    endfunction

    function automatic void queue_write(input int unsigned addr, input logic [7:0] pix);
        store_write_t w;
        if (addr < STORE_END)
        begin
            w.addr = addr[9:0];
            w.pix  = pix;
            w.last = 1'b0;
            pending_writes.push_back(w);
        end
    endfunction

    function automatic int predict_char(input logic ns, input logic [7:0] code);
        logic [39:0] cols;
        logic [7:0]  g;
        int unsigned p;
        int          first;
        cols  = '0;
        first = pending_writes.size();
        if (ns)
        begin
            cursor     = 0;
            page_row   = 0;
            glyph_size = SIZE_NORMAL;
        end
        if (code == CHAR_PIPE)
        begin
            if (page_row + 1 < PC)
            begin
                page_row++;
                cursor = page_row * PW;
            end
            else
            begin
                page_row = PC - 1;
                cursor   = STORE_END;
            end
            return 0;
        end
        if (cursor % PW == 0 && (code == CHAR_ONE || code == CHAR_TWO || code == CHAR_FOUR))
        begin
            if (code == CHAR_ONE)
            begin
                glyph_size = SIZE_NORMAL;
            end
            else if (code == CHAR_TWO)
            begin
                glyph_size = SIZE_DOUBLE;
            end
            else
            begin
                glyph_size = SIZE_QUAD;
            end
            bump_cursor();
            return 0;
        end
        if (code >= CODE_FIRST && code <= CODE_LAST)
        begin
            cols = FONT_COLUMNS[code - CODE_FIRST];
        end
        for (int c = 0; c < 5; c++)
        begin
            g = cols[39 - 8*c -: 8];
            p = cursor;
            if (glyph_size == SIZE_QUAD)
            begin
                bump_cursor();
                bump_cursor();
                queue_write(p + 1, double_rows(g[3:0]));
                queue_write(p, double_rows(g[3:0]));
                queue_write(p + PW + 1, double_rows(g[7:4]));
                queue_write(p + PW, double_rows(g[7:4]));
            end
            else if (glyph_size == SIZE_DOUBLE)
            begin
                queue_write(cursor, g);
                bump_cursor();
                queue_write(cursor, g);
                bump_cursor();
            end
            else
            begin
                queue_write(cursor, g);
                bump_cursor();
            end
        end
        bump_cursor();
        if (pending_writes.size() > first)
        begin
            pending_writes[pending_writes.size() - 1].last = 1'b1;
        end
        return pending_writes.size() - first;
    endfunction

    function automatic logic [7:0] pick_code(input bit string_start);
        int r;
        r = $urandom_range(99);
        if ((string_start && $urandom_range(1) == 1) || (r >= 12 && r < 22))
        begin
            case ($urandom_range(2))
                0:       return CHAR_ONE;
                1:       return CHAR_TWO;
                default: return CHAR_FOUR;
            endcase
        end
        if (r < 12)
        begin
            return CHAR_PIPE;
        end
        if (r < 82)
        begin
            return 8'($urandom_range(CODE_LAST, CODE_FIRST));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic offer_char(input logic ns, input logic [7:0] code);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        new_string <= ns;
        char_code  <= code;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        last_count = predict_char(ns, code);
    endtask

    task automatic random_strings(input int n_items);
        int   sent;
        int   len;
        logic ns;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(40, 1);
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                ns = (k == 0) || ($urandom_range(49) == 0);
                offer_char(ns, pick_code(ns));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen   <= hold_toggle;
            hold_cycles <= HOLD_LEN;
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, store_address %0d pixel_byte %02h",
                         $time, store_address, pixel_byte);
            end
            else
            begin
                oldest_write = pending_writes.pop_front();
                if (store_address !== oldest_write.addr)
                begin
                    errors++;
                    $display("%0t: store_address expected %0d, got %0d",
                             $time, oldest_write.addr, store_address);
                end
                if (pixel_byte !== oldest_write.pix)
                begin
                    errors++;
                    $display("%0t: pixel_byte expected %02h, got %02h",
                             $time, oldest_write.pix, pixel_byte);
                end
                if (last_write !== oldest_write.last)
                begin
                    errors++;
                    $display("%0t: last_write expected %0b, got %0b",
                             $time, oldest_write.last, last_write);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("text_to_page_framebuffer_writer_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            offer_char(SCRIPT[i].ns, SCRIPT[i].code);
            if (SCRIPT[i].typed && (last_count != SCRIPT[i].count || (last_count > 0 &&
                (pending_writes[pending_writes.size() - last_count].addr != SCRIPT[i].a0 ||
                 pending_writes[pending_writes.size() - last_count].pix != SCRIPT[i].b0))))
            begin
                errors++;
                $display("%0t: row %0d expected %0d words from %0d/%02h, predicted %0d",
                         $time, i, SCRIPT[i].count, SCRIPT[i].a0, SCRIPT[i].b0, last_count);
            end
        end

        // The long output hold lands while the sender keeps the input busy.
        hold_toggle <= ~hold_toggle;
        random_strings(RANDOM_PER_PHASE);

        idle_pct  = 81;
        stall_pct = 0;
        random_strings(RANDOM_PER_PHASE);

        idle_pct  = 0;
        stall_pct = 81;
        random_strings(RANDOM_PER_PHASE);

        idle_pct  = 27;
        stall_pct = 27;
        random_strings(RANDOM_PER_PHASE);

        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
        begin
            $display("text_to_page_framebuffer_writer_tb: done, clean");
        end
        else
        begin
            $display("text_to_page_framebuffer_writer_tb: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/tpfw_pkg.sv
hdl/tpfw_ctrl.sv
hdl/tpfw_datapath.sv
hdl/text_to_page_framebuffer_writer.sv
tb/text_to_page_framebuffer_writer_tb.sv
